// ===== rtl/motor_feedback_multiturn_tracker_top_assert.svh =====
// Assertion macros shared by the multi-turn tracker RTL.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_TOP_ASSERT_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mft_pkg.sv =====
// Package with the types and constants of the multi-turn tracker.
package mft_pkg;

    // CAN identifier of the first motor.
    localparam logic [10:0] BASE_ID = 11'h201;

    // Field widths.
    localparam int ID_W    = 11;
    localparam int WORD_W  = 16;
    localparam int TEMP_W  = 8;
    localparam int IDX_W   = 3;
    localparam int TOTAL_W = 30;
    localparam int CNT_W   = 8;

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 96;

    // Reset value of the calibration limit.
    localparam logic [CNT_W-1:0] CAL_FRAMES_RST = 8'd50;

    // Per-motor state as kept in one memory entry.
    typedef struct packed {
        logic [TOTAL_W-1:0] accum_angle;
        logic [CNT_W-1:0]   frame_cnt;
        logic [WORD_W-1:0]  rev_cnt;
        logic [WORD_W-1:0]  zero_pos;
        logic [WORD_W-1:0]  prev_pos;
    } t_motor_state;

    localparam int STATE_W = $bits(t_motor_state);

endpackage

// ===== rtl/motor_feedback_multiturn_tracker_top.sv =====
// Top level of the multi-turn rotor angle tracker for CAN motor feedback.
//
// The block takes one feedback frame per word and, for identifiers 0x201 up to
// 0x201+MOTOR_COUNT-1, returns one result word with the decoded fields and the
// unwrapped total angle; frames with any other identifier are taken and dropped.
// One frame per clock cycle is sustained while the output is not stalled; an
// accepted frame passes the update stage and output registers. Per-motor state
// is in one RAM, read when a frame is accepted, updated and written back as it
// leaves the update stage; the latest write is forwarded to a later frame of
// that motor. Reset clears each entry's valid bit, so no clearing pass is run.
`include "motor_feedback_multiturn_tracker_top_assert.svh"

module motor_feedback_multiturn_tracker_top
    import mft_pkg::*;
#(
    parameter int MOTOR_COUNT    = 8,
    parameter int COUNTS_PER_REV = 8192
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Calibration limit register.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CNT_W-1:0]       i_cfg_data,
    // Frame input.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: frame_id, angle_word, speed_word, current_word, temperature_byte
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result output.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: motor_index, rotor angle, rotor_speed, motor_current,
    //        motor_temperature, total angle
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: calibrating
    output logic [0:0]             m_axis_tuser
);

    localparam int MW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int PW = 34;
    localparam logic signed [17:0] HALF_REV = 18'(COUNTS_PER_REV / 2);
    localparam logic signed [PW-1:0] CPR_S = PW'(COUNTS_PER_REV);

    // Configuration register.
    logic [CNT_W-1:0] r_cal_frames;

    // Input decode.
    logic              s_acc;
    logic [ID_W-1:0]   in_id;
    logic [ID_W-1:0]   in_off;
    logic              in_hit;

    // Update stage.
    logic              r_s1_vld;
    logic [MW-1:0]     r_s1_addr;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [WORD_W-1:0] r_s1_ang;
    logic [WORD_W-1:0] r_s1_speed;
    logic [WORD_W-1:0] r_s1_cur;
    logic [TEMP_W-1:0] r_s1_temp;
    logic              r_s1_ent_vld;
    logic              s1_adv;

    // State memory, valid bits and last-write bypass.
    logic [MOTOR_COUNT-1:0] r_vld;
    t_motor_state           ram_rdata;
    logic                   r_wr_vld;
    logic [MW-1:0]          r_wr_addr;
    t_motor_state           r_wr_data;
    t_motor_state           cur;
    t_motor_state           wr_data;
    logic                   wr_en;

    // Arithmetic.
    logic                     s1_cal;
    logic signed [17:0]       diff;
    logic [WORD_W-1:0]        rev_nxt;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     total;

    // Output register.
    logic               r_out_vld;
    logic [IDX_W-1:0]   r_out_idx;
    logic [WORD_W-1:0]  r_out_ang;
    logic [WORD_W-1:0]  r_out_speed;
    logic [WORD_W-1:0]  r_out_cur;
    logic [TEMP_W-1:0]  r_out_temp;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_cal;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_frames <= CAL_FRAMES_RST;
        end else if (i_cfg_valid) begin
            r_cal_frames <= i_cfg_data;
        end
    end

    // Identifier decode: known motors map to a RAM address.
    assign in_id  = s_axis_tdata[10:0];
    assign in_off = in_id - BASE_ID;
    assign in_hit = (in_id >= BASE_ID) && (in_off < ID_W'(MOTOR_COUNT));

    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // Update stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= in_hit;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Update stage payload, captured with the memory read.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_addr    <= in_off[MW-1:0];
            r_s1_idx     <= in_off[IDX_W-1:0];
            r_s1_ang     <= s_axis_tdata[26:11];
            r_s1_speed   <= s_axis_tdata[42:27];
            r_s1_cur     <= s_axis_tdata[58:43];
            r_s1_temp    <= s_axis_tdata[66:59];
            r_s1_ent_vld <= r_vld[in_off[MW-1:0]];
        end
    end

    mft_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MOTOR_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_data),
        .i_re    (s_acc),
        .i_raddr (in_off[MW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Current motor state: latest write first, then memory, else reset value.
    always_comb begin
        if (r_wr_vld && (r_wr_addr == r_s1_addr)) begin
            cur = r_wr_data;
        end else if (r_s1_ent_vld) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end
    end

    // Calibration check and revolution tracking.
    assign s1_cal = cur.frame_cnt <= r_cal_frames;
    assign diff   = 18'(signed'(r_s1_ang)) - 18'(signed'(cur.prev_pos));

    always_comb begin
        if (diff > HALF_REV) begin
            rev_nxt = cur.rev_cnt - 16'd1;
        end else if (diff < -HALF_REV) begin
            rev_nxt = cur.rev_cnt + 16'd1;
        end else begin
            rev_nxt = cur.rev_cnt;
        end
    end

    assign prod  = PW'(signed'(rev_nxt)) * CPR_S;
    assign total = prod + PW'(signed'(r_s1_ang)) - PW'(signed'(cur.zero_pos));

    // New state of the motor.
    always_comb begin
        wr_data = cur;
        wr_data.prev_pos = r_s1_ang;
        if (s1_cal) begin
            wr_data.zero_pos = r_s1_ang;
            if (cur.frame_cnt != 8'hFF) begin
                wr_data.frame_cnt = cur.frame_cnt + 8'd1;
            end
        end else begin
            wr_data.rev_cnt     = rev_nxt;
            wr_data.accum_angle = total[TOTAL_W-1:0];
        end
    end

    assign wr_en = s1_adv;

    // Valid bits and the copy of the latest write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wr_vld <= 1'b0;
        end else if (wr_en) begin
            r_vld[r_s1_addr] <= 1'b1;
            r_wr_vld         <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= wr_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_idx   <= r_s1_idx;
            r_out_ang   <= r_s1_ang;
            r_out_speed <= r_s1_speed;
            r_out_cur   <= r_s1_cur;
            r_out_temp  <= r_s1_temp;
            r_out_total <= wr_data.accum_angle;
            r_out_cal   <= s1_cal;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out_total, r_out_temp, r_out_cur, r_out_speed,
                            r_out_ang, r_out_idx};
    assign m_axis_tuser  = r_out_cal;

    // Checks on the pipeline and the state update.
    `MFT_ASSERT_NEXT(a_acc_hit_fills, s_acc && in_hit, r_s1_vld, "known frame not staged")
    `MFT_ASSERT_NEXT(a_wr_sets_vld, wr_en, r_vld[r_wr_addr], "written entry not valid")
    `MFT_ASSERT_SAME(a_cal_offset, wr_en && s1_cal,
                     wr_data.zero_pos == wr_data.prev_pos,
                     "calibration offset differs from last angle")

endmodule

// ===== rtl/mft_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
